FILE: rtl/dtdlp_pkg.sv
package dtdlp_pkg;

  localparam int unsigned DefMaxWidth  = 512;
  localparam int unsigned DefMaxHeight = 512;
  localparam int unsigned DefMaxSteps  = 4096;

  localparam int unsigned NumCfgRegs = 6;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStep    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScale   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutline = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBack    = 3'd5;

  localparam logic [1:0] ModeDot   = 2'd0;
  localparam logic [1:0] ModeLine  = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic [15:0] DepthMask  = 16'hFFF0;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam int          OutlineAdd = 64;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [19:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [19:0] end_z;
    logic [3:0]         colour;
  } req_t;

  typedef struct packed {
    logic [15:0] read_word;
    logic [15:0] written_count;
    logic [15:0] rejected_count;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_t;

endpackage

FILE: rtl/dtdlp_if.sv
interface dtdlp_req_if;
  logic              valid;
  logic              ready;
  dtdlp_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dtdlp_rsp_if;
  logic              valid;
  logic              ready;
  dtdlp_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dtdlp_cfg_if;
  logic              valid;
  logic              ready;
  dtdlp_pkg::cfg_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/depth_tested_dot_line_plotter.sv
// A line first runs its setup (root, divide by the step, three divides by n), then plots n+1
// dots. A pixel outside the image skips the memory read and the depth test.
// A clear writes one word per cycle over all MAX_WIDTH*MAX_HEIGHT words, and the same pass runs
// after reset. One request at a time; reset is asynchronous, active low, to defaults.
module depth_tested_dot_line_plotter #(
  parameter int unsigned MAX_WIDTH  = dtdlp_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = dtdlp_pkg::DefMaxHeight,
  parameter int unsigned MAX_STEPS  = dtdlp_pkg::DefMaxSteps
) (
  input  logic clk_i,
  input  logic rst_ni,
  dtdlp_req_if.sink   req_i,
  dtdlp_rsp_if.source rsp_o,
  dtdlp_cfg_if.sink   cfg_i
);
  import dtdlp_pkg::*;

  localparam int unsigned Words = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Words);
  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);

  // Sequencer states.
  localparam logic [4:0] StClr   = 5'd0;
  localparam logic [4:0] StIdle  = 5'd1;
  localparam logic [4:0] StSqA   = 5'd2;
  localparam logic [4:0] StSqB   = 5'd3;
  localparam logic [4:0] StSqC   = 5'd4;
  localparam logic [4:0] StSqrt  = 5'd5;
  localparam logic [4:0] StDivR  = 5'd6;
  localparam logic [4:0] StLdA   = 5'd7;
  localparam logic [4:0] StDivA  = 5'd8;
  localparam logic [4:0] StFix   = 5'd9;
  localparam logic [4:0] StDepth = 5'd10;
  localparam logic [4:0] StScale = 5'd11;
  localparam logic [4:0] StRd    = 5'd12;
  localparam logic [4:0] StRdW   = 5'd13;
  localparam logic [4:0] StTest  = 5'd14;
  localparam logic [4:0] StNext  = 5'd15;
  localparam logic [4:0] StRsp   = 5'd16;

  logic [4:0] st_q;

  logic [9:0]  width_q, height_q;
  logic [15:0] step_q, scale_q, back_q;
  logic [3:0]  outline_q;

  req_t r_q;
  logic [AW-1:0] clr_q;

  // Shared restoring unit for the root and all divides.
  logic [41:0] num_q;
  logic [23:0] rem_q;
  logic [20:0] quo_q;
  logic [4:0]  cnt_q;
  logic [NW-1:0] n_q, i_q;
  logic [1:0]  ax_q;      // axis being divided: 0 x, 1 y, 2 z
  logic signed [43:0] prod_q;
  logic [2:0]  nb_q;      // neighbour index; 4 is the centre
  logic signed [17:0] cx_q, cy_q;
  logic [15:0] dep_q;
  logic [AW-1:0] addr_q;
  logic [15:0] wcnt_q, rcnt_q, word_q;

  // Per-axis line stepping: quotient and remainder of delta/n, and running sums.
  logic signed [21:0] stq_q [3];
  logic [NW-1:0]      str_q [3];
  logic signed [21:0] acq_q [3];
  logic [NW-1:0]      acr_q [3];

  logic [15:0] rdata;
  logic        we;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;

  logic signed [20:0] dx, dy, dz;
  assign dx = 21'($signed(r_q.end_x)) - 21'($signed(r_q.start_x));
  assign dy = 21'($signed(r_q.end_y)) - 21'($signed(r_q.start_y));
  assign dz = 21'($signed(r_q.end_z)) - 21'($signed(r_q.start_z));

  logic signed [21:0] qx, qy, qz;
  assign qx = 22'($signed(r_q.start_x)) + acq_q[0];
  assign qy = 22'($signed(r_q.start_y)) + acq_q[1];
  assign qz = 22'($signed(r_q.start_z)) + acq_q[2];

  logic [12:0] wlim, hlim;
  assign wlim = (32'(width_q)  < MAX_WIDTH)  ? 13'(width_q)  : 13'(MAX_WIDTH);
  assign hlim = (32'(height_q) < MAX_HEIGHT) ? 13'(height_q) : 13'(MAX_HEIGHT);

  // Current pixel, with the neighbour offset for outline dots.
  logic signed [17:0] px, py;
  always_comb begin
    px = cx_q;
    py = cy_q;
    case (nb_q)
      3'd0:    px = cx_q + 18'sd1;
      3'd1:    px = cx_q - 18'sd1;
      3'd2:    py = cy_q + 18'sd1;
      3'd3:    py = cy_q - 18'sd1;
      default: ;
    endcase
  end
  logic in_img;
  assign in_img = !px[17] && !py[17] && (px[16:0] < 17'(wlim)) && (py[16:0] < 17'(hlim));

  // Pixel of a Q.4 value, truncated toward zero.
  function automatic logic signed [17:0] pix(input logic signed [21:0] q);
    logic signed [21:0] t;
    t = q + (q[21] ? 22'sd15 : 22'sd0);
    return 18'(t >>> 4);
  endfunction

  logic [15:0] step_eff;
  assign step_eff = (step_q == 16'd0) ? 16'd1 : step_q;

  logic signed [20:0] delta_sel;
  always_comb begin
    case (ax_q)
      2'd0:    delta_sel = dx;
      2'd1:    delta_sel = dy;
      default: delta_sel = dz;
    endcase
  end
  logic [20:0] dmag;
  assign dmag = delta_sel[20] ? 21'(-delta_sel) : 21'(delta_sel);

  // One subtract-and-compare step, two bits for the root and one for a divide.
  logic        sqrt_mode;
  logic [23:0] rem_sh, trial, rem_nx;
  logic [24:0] diff;
  logic        ge;
  logic [20:0] quo_nx;
  always_comb begin
    sqrt_mode = (st_q == StSqrt);
    if (sqrt_mode) begin
      rem_sh = {rem_q[21:0], num_q[41:40]};
      trial  = {1'b0, quo_q, 2'b01};
    end else begin
      rem_sh = {6'd0, rem_q[16:0], num_q[41]};
      trial  = (st_q == StDivR) ? 24'(step_eff) : 24'(n_q);
    end
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    ge     = !diff[24];
    rem_nx = ge ? diff[23:0] : rem_sh;
    quo_nx = {quo_q[19:0], ge};
  end

  logic [NW-1:0] n_nx;
  assign n_nx = (quo_nx >= 21'(MAX_STEPS - 1)) ? NW'(MAX_STEPS) : NW'(quo_nx + 21'd1);

  logic [NW:0] sum_r [3];
  always_comb begin
    for (int k = 0; k < 3; k++) sum_r[k] = {1'b0, acr_q[k]} + {1'b0, str_q[k]};
  end

  // Shared multiplier: squares of the deltas, then depth scaling.
  logic signed [21:0] mul_a, mul_b;
  always_comb begin
    if (st_q == StSqA) begin
      mul_a = 22'(dx); mul_b = 22'(dx);
    end else if (st_q == StSqB) begin
      mul_a = 22'(dy); mul_b = 22'(dy);
    end else begin
      mul_a = $signed({6'd0, scale_q}); mul_b = qz;
    end
  end

  // Depth: scaled z truncated toward zero, raised for outline dots, then clamped.
  logic signed [43:0] zt, zs;
  logic [15:0] dep_nx;
  always_comb begin
    zt = prod_q + (prod_q[43] ? 44'sd4095 : 44'sd0);
    zs = (zt >>> 12) + ((r_q.colour == outline_q) ? 44'(OutlineAdd) : 44'sd0);
    dep_nx = zs[43] ? 16'd0 : ((zs > 44'sd65535) ? 16'hFFFF : 16'(zs));
  end

  logic cfg_ok, req_ok, rsp_ok;
  assign req_i.ready = (st_q == StIdle);
  assign cfg_i.ready = (st_q == StIdle);
  assign req_ok = req_i.valid && req_i.ready;
  assign cfg_ok = cfg_i.valid && cfg_i.ready;
  assign rsp_o.valid = (st_q == StRsp);
  assign rsp_o.payload = '{read_word: word_q, written_count: wcnt_q,
                           rejected_count: rcnt_q};
  assign rsp_ok = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 10'd512; height_q <= 10'd512;
      step_q <= 16'd256; scale_q <= 16'd256;
      outline_q <= 4'd15; back_q <= 16'd0;
    end else if (cfg_ok) begin
      unique case (cfg_i.payload.index)
        RegWidth:   width_q   <= cfg_i.payload.data[9:0];
        RegHeight:  height_q  <= cfg_i.payload.data[9:0];
        RegStep:    step_q    <= cfg_i.payload.data[15:0];
        RegScale:   scale_q   <= cfg_i.payload.data[15:0];
        RegOutline: outline_q <= cfg_i.payload.data[3:0];
        RegBack:    back_q    <= cfg_i.payload.data[15:0];
        default: ;
      endcase
    end
  end

  dtdlp_ram #(.Width(16), .Depth(Words)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(addr_q), .rdata_o(rdata)
  );

  logic [AW-1:0] pix_addr;
  assign pix_addr = AW'(AW'(py[16:0]) * AW'(MAX_WIDTH) + AW'(px[16:0]));
  logic [15:0] plot_word;
  assign plot_word = (dep_q & DepthMask) | {12'd0, r_q.colour};
  logic pass;
  assign pass = rdata < dep_q;

  always_comb begin
    we = 1'b0; waddr = addr_q; wdata = plot_word;
    if (st_q == StClr) begin
      we = 1'b1; waddr = clr_q; wdata = back_q;
    end else if (st_q == StTest && r_q.mode != ModeRead && pass) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; r_q <= '0;
      num_q <= '0; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
      n_q <= '0; i_q <= '0; ax_q <= '0; prod_q <= '0; nb_q <= 3'd4;
      cx_q <= '0; cy_q <= '0; dep_q <= '0; addr_q <= '0;
      wcnt_q <= '0; rcnt_q <= '0; word_q <= '0;
      for (int k = 0; k < 3; k++) begin
        stq_q[k] <= '0; str_q[k] <= '0; acq_q[k] <= '0; acr_q[k] <= '0;
      end
    end else begin
      unique case (st_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Words - 1)) begin
            st_q <= (r_q.mode == ModeClear) ? StRsp : StIdle;
          end
        end
        StIdle: if (req_ok) begin
          r_q <= req_i.payload; wcnt_q <= '0; rcnt_q <= '0; word_q <= '0;
          cx_q <= pix(22'($signed(req_i.payload.start_x)));
          cy_q <= pix(22'($signed(req_i.payload.start_y)));
          nb_q <= 3'd4; i_q <= '0;
          for (int k = 0; k < 3; k++) begin
            acq_q[k] <= '0; acr_q[k] <= '0;
          end
          unique case (req_i.payload.mode)
            ModeDot:  st_q <= StDepth;
            ModeLine: st_q <= StSqA;
            ModeRead: st_q <= StRd;
            default: begin
              clr_q <= '0; st_q <= StClr;
            end
          endcase
        end
        StSqA: begin
          prod_q <= mul_a * mul_b; st_q <= StSqB;
        end
        StSqB: begin
          num_q <= 42'(prod_q); prod_q <= mul_a * mul_b; st_q <= StSqC;
        end
        StSqC: begin
          // 256*D, root taken two bits a cycle.
          num_q <= 42'((num_q + 42'(prod_q)) << 8);
          rem_q <= '0; quo_q <= '0; cnt_q <= 5'd21; st_q <= StSqrt;
        end
        StSqrt: begin
          if (cnt_q == 5'd1) begin
            num_q <= {quo_nx, 21'd0};
            rem_q <= '0; quo_q <= '0; cnt_q <= 5'd21; st_q <= StDivR;
          end else begin
            num_q <= num_q << 2; rem_q <= rem_nx; quo_q <= quo_nx;
            cnt_q <= cnt_q - 5'd1;
          end
        end
        StDivR: begin
          if (cnt_q == 5'd1) begin
            n_q <= n_nx; ax_q <= 2'd0; st_q <= StLdA;
          end else begin
            num_q <= num_q << 1; rem_q <= rem_nx; quo_q <= quo_nx;
            cnt_q <= cnt_q - 5'd1;
          end
        end
        StLdA: begin
          num_q <= {dmag, 21'd0}; rem_q <= '0; quo_q <= '0;
          cnt_q <= 5'd21; st_q <= StDivA;
        end
        StDivA: begin
          num_q <= num_q << 1; rem_q <= rem_nx; quo_q <= quo_nx;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) st_q <= StFix;
        end
        StFix: begin
          // Turn the magnitude divide into a floor divide with a remainder in 0..n-1.
          if (delta_sel[20] && (rem_q[NW-1:0] != '0)) begin
            stq_q[ax_q] <= -22'(quo_q) - 22'sd1;
            str_q[ax_q] <= n_q - rem_q[NW-1:0];
          end else begin
            stq_q[ax_q] <= delta_sel[20] ? -22'(quo_q) : 22'(quo_q);
            str_q[ax_q] <= rem_q[NW-1:0];
          end
          if (ax_q == 2'd2) begin
            st_q <= StDepth;
          end else begin
            ax_q <= ax_q + 2'd1; st_q <= StLdA;
          end
        end
        StDepth: begin
          cx_q <= pix(qx); cy_q <= pix(qy);
          prod_q <= mul_a * mul_b; st_q <= StScale;
        end
        StScale: begin
          dep_q <= dep_nx;
          nb_q <= (r_q.colour == outline_q) ? 3'd0 : 3'd4;
          st_q <= StRd;
        end
        StRd: begin
          if (in_img) begin
            addr_q <= pix_addr; st_q <= StRdW;
          end else if (r_q.mode == ModeRead) begin
            st_q <= StRsp;
          end else if (nb_q != 3'd4) begin
            nb_q <= nb_q + 3'd1;
          end else begin
            st_q <= StNext;
          end
        end
        StRdW: st_q <= StTest;
        StTest: begin
          if (r_q.mode == ModeRead) begin
            word_q <= rdata; st_q <= StRsp;
          end else begin
            if (pass) begin
              if (wcnt_q != CountMax) wcnt_q <= wcnt_q + 1'b1;
            end else if (rcnt_q != CountMax) begin
              rcnt_q <= rcnt_q + 1'b1;
            end
            if (nb_q != 3'd4) begin
              nb_q <= nb_q + 3'd1; st_q <= StRd;
            end else begin
              st_q <= StNext;
            end
          end
        end
        StNext: begin
          if (r_q.mode == ModeLine && i_q != n_q) begin
            i_q <= i_q + NW'(1);
            for (int k = 0; k < 3; k++) begin
              if (sum_r[k] >= {1'b0, n_q}) begin
                acr_q[k] <= NW'(sum_r[k] - {1'b0, n_q});
                acq_q[k] <= acq_q[k] + stq_q[k] + 22'sd1;
              end else begin
                acr_q[k] <= NW'(sum_r[k]);
                acq_q[k] <= acq_q[k] + stq_q[k];
              end
            end
            st_q <= StDepth;
          end else begin
            st_q <= StRsp;
          end
        end
        StRsp: if (rsp_ok) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !rsp_o.valid) else $error("ready while response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid) else $error("response dropped");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !we) else $error("write while idle");
`endif
endmodule

FILE: rtl/dtdlp_ram.sv
module dtdlp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: verif/depth_tested_dot_line_plotter_tb.sv
`timescale 1ns / 100ps
module depth_tested_dot_line_plotter_tb;
  import dtdlp_pkg::*;

  localparam int MaxW       = DefMaxWidth;
  localparam int MaxH       = DefMaxHeight;
  localparam int MaxSteps   = DefMaxSteps;
  localparam int CycleLimit = 4_000_000;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  dtdlp_req_if req_bus();
  dtdlp_rsp_if rsp_bus();
  dtdlp_cfg_if cfg_bus();

  depth_tested_dot_line_plotter DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  // Shadow of the pixel store and of the registers.
  logic [15:0] depth_words [MaxW*MaxH];
  int unsigned width_reg, height_reg, step_reg, scale_reg, outline_reg, back_reg;
  int unsigned pix_written, pix_rejected;

  rsp_t        awaited_rsp [$];
  plan_row_t   plan [$];
  int          mismatches;
  int          rsp_seen;
  bit          calm;
  longint      cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q -= 1;
    return q;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned bval;
    r = 0;
    bval = 64'h4000_0000_0000_0000;
    while (bval > v) bval >>= 2;
    while (bval != 0) begin
      if (v >= r + bval) begin
        v -= r + bval;
        r = (r >> 1) + bval;
      end else begin
        r >>= 1;
      end
      bval >>= 2;
    end
    return r;
  endfunction

  function automatic bit on_image(longint x, longint y);
    longint w;
    longint h;
    w = (width_reg < MaxW) ? width_reg : MaxW;
    h = (height_reg < MaxH) ? height_reg : MaxH;
    return x >= 0 && y >= 0 && x < w && y < h;
  endfunction

  function automatic void plot_px(longint x, longint y, longint z, logic [3:0] c);
    int unsigned idx;
    if (!on_image(x, y)) return;
    if (z < 0) z = 0;
    if (z > 65535) z = 65535;
    idx = int'(y * MaxW + x);
    if (longint'(depth_words[idx]) >= z) begin
      if (pix_rejected < 65535) pix_rejected++;
      return;
    end
    depth_words[idx] = (16'(z) & DepthMask) | {12'h000, c};
    if (pix_written < 65535) pix_written++;
  endfunction

  function automatic void put_dot(longint qx, longint qy, longint qz, logic [3:0] c);
    longint x;
    longint y;
    longint z;
    x = qx / 16;
    y = qy / 16;
    z = (longint'(scale_reg) * qz) / 4096;
    if (c == outline_reg[3:0]) begin
      z += OutlineAdd;
      plot_px(x + 1, y, z, c);
      plot_px(x - 1, y, z, c);
      plot_px(x, y + 1, z, c);
      plot_px(x, y - 1, z, c);
    end
    plot_px(x, y, z, c);
  endfunction

  function automatic rsp_t plot_outcome(req_t r);
    rsp_t   o;
    longint sx, sy, sz, dx, dy, dz, n;
    longint unsigned len_sq, root, st;
    sx = longint'($signed(r.start_x));
    sy = longint'($signed(r.start_y));
    sz = longint'($signed(r.start_z));
    dx = longint'($signed(r.end_x)) - sx;
    dy = longint'($signed(r.end_y)) - sy;
    dz = longint'($signed(r.end_z)) - sz;
    o = '0;
    pix_written = 0;
    pix_rejected = 0;
    case (r.mode)
      ModeDot: put_dot(sx, sy, sz, r.colour);
      ModeLine: begin
        len_sq = longint'(dx * dx) + longint'(dy * dy);
        root = int_root(len_sq * 256);
        st = (step_reg == 0) ? 1 : step_reg;
        n = longint'(1 + root / st);
        if (n > MaxSteps) n = MaxSteps;
        for (longint i = 0; i <= n; i++)
          put_dot(sx + floor_div(dx * i, n), sy + floor_div(dy * i, n),
                  sz + floor_div(dz * i, n), r.colour);
      end
      ModeRead: begin
        if (on_image(sx / 16, sy / 16))
          o.read_word = depth_words[int'((sy / 16) * MaxW + sx / 16)];
      end
      default: begin
        foreach (depth_words[k]) depth_words[k] = back_reg[15:0];
      end
    endcase
    o.written_count = 16'(pix_written);
    o.rejected_count = 16'(pix_rejected);
    return o;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_bus.valid = 1'b1;
    cfg_bus.payload.index = idx;
    cfg_bus.payload.data = val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      RegWidth:   width_reg = val & 32'h3FF;
      RegHeight:  height_reg = val & 32'h3FF;
      RegStep:    step_reg = val & 32'hFFFF;
      RegScale:   scale_reg = val & 32'hFFFF;
      RegOutline: outline_reg = val & 32'hF;
      RegBack:    back_reg = val & 32'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_req(req_t r, bit typed, rsp_t want);
    rsp_t guess;
    while (!calm && $urandom_range(99) < 32) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.payload = r;
    do @(posedge clk); while (!req_bus.ready);
    guess = plot_outcome(r);
    awaited_rsp.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic drain();
    req_bus.valid = 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic void add_row(logic [1:0] mode, int sx, int sy, int sz, int ex, int ey,
                                  int ez, logic [3:0] col, bit typed, logic [15:0] word,
                                  logic [15:0] wr, logic [15:0] rj);
    plan_row_t p;
    p.req = '{mode, 16'(sx), 16'(sy), 20'(sz), 16'(ex), 16'(ey), 20'(ez), col};
    p.typed = typed;
    p.want = '{word, wr, rj};
    plan.push_back(p);
  endfunction

  function automatic int pick_coord(int lim);
    if ($urandom_range(9) == 0) return int'($urandom_range(65535)) - 32768;
    return (int'($urandom_range(lim + 1)) - 1) * 16 + int'($urandom_range(15));
  endfunction

  function automatic int pick_depth();
    if ($urandom_range(3) == 0) return int'($urandom_range(1048575)) - 524288;
    return int'($urandom_range(220000)) - 20000;
  endfunction

  function automatic int pick_end(int s, int dmax);
    int dlt;
    int e;
    dlt = int'($urandom_range(2 * dmax)) - dmax;
    e = s + dlt;
    if (e > 32767 || e < -32768) e = s - dlt;
    return e;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   wl, hl, dmax, sel;
    wl = (width_reg < MaxW) ? width_reg : MaxW;
    hl = (height_reg < MaxH) ? height_reg : MaxH;
    if (wl > 20) wl = 20;
    if (hl > 20) hl = 20;
    // Short lines keep the dot count low whatever the spacing.
    dmax = ((step_reg == 0) ? 1 : step_reg) / 32 + 1;
    sel = $urandom_range(99);
    r.mode = (sel < 45) ? ModeDot : (sel < 85) ? ModeLine : ModeRead;
    r.start_x = 16'(pick_coord(wl));
    r.start_y = 16'(pick_coord(hl));
    r.start_z = 20'(pick_depth());
    r.end_x = 16'(pick_end(int'($signed(r.start_x)), dmax));
    r.end_y = 16'(pick_end(int'($signed(r.start_y)), dmax));
    r.end_z = 20'(pick_depth());
    r.colour = ($urandom_range(3) == 0) ? outline_reg[3:0] : 4'($urandom_range(15));
    return r;
  endfunction

  task automatic run_batch(int count);
    repeat (count) send_req(random_req(), 1'b0, '0);
  endtask

  // Response side: random stalls and one long hold-off that backs up the block.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_bus.ready = 1'b0;
        hold_left--;
      end else begin
        if (!held && rsp_seen >= 40) begin
          held = 1'b1;
          hold_left = 500;
        end
        rsp_bus.ready = calm || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      rsp_seen++;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_bus.payload);
      end else begin
        exp_r = awaited_rsp.pop_front();
        if (rsp_bus.payload.read_word !== exp_r.read_word ||
            rsp_bus.payload.written_count !== exp_r.written_count ||
            rsp_bus.payload.rejected_count !== exp_r.rejected_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected %p, got %p", exp_r, rsp_bus.payload);
        end
      end
    end
  end

  initial begin
    int unsigned bg;
    req_bus.valid = 1'b0;
    req_bus.payload = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.payload = '0;
    width_reg = 512;
    height_reg = 512;
    step_reg = 256;
    scale_reg = 256;
    outline_reg = 15;
    back_reg = 0;
    foreach (depth_words[k]) depth_words[k] = '0;
    calm = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    bg = $urandom_range(16'h3FFF);
    write_reg(RegBack, bg);

    add_row(ModeRead, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(ModeDot, 0, 0, 524287, 0, 0, 0, 3, 1, 0, 1, 0);
    add_row(ModeRead, 0, 0, 0, 0, 0, 0, 0, 1, 16'h7FF3, 0, 0);
    // A negative depth clamps to zero and loses against an empty pixel.
    add_row(ModeDot, 80, 80, -524288, 0, 0, 0, 2, 1, 0, 0, 1);
    add_row(ModeDot, -16, 0, 1000, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(ModeDot, 32767, 0, 1000, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(ModeDot, -32768, -32768, 1000, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(ModeDot, 0, 0, 1600, 0, 0, 0, 15, 0, 0, 0, 0);
    add_row(ModeDot, 160, 160, 524287, 0, 0, 0, 15, 1, 0, 5, 0);
    add_row(ModeLine, 320, 320, 1000, 320, 320, 1000, 1, 0, 0, 0, 0);
    add_row(ModeLine, 0, 480, 2000, 1600, 640, 90000, 4, 0, 0, 0, 0);
    add_row(ModeLine, 480, 480, 300000, -80, 32, -5000, 9, 0, 0, 0, 0);
    add_row(ModeLine, 100, 200, 40000, 300, 50, 60000, 15, 0, 0, 0, 0);
    add_row(ModeLine, 32767, 32767, 524287, 32700, 32767, 524287, 14, 0, 0, 0, 0);
    // Long enough to hit the dot count ceiling.
    add_row(ModeLine, -32768, -32768, -524288, 32767, 32767, 524287, 5, 0, 0, 0, 0);
    add_row(ModeRead, -16, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(ModeRead, 9600, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(ModeRead, 8191, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ModeRead, 32767, -32768, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(ModeClear, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(ModeRead, 160, 160, 0, 0, 0, 0, 0, 1, 16'(bg), 0, 0);
    add_row(ModeDot, 160, 160, 0, 0, 0, 0, 0, 1, 0, 0, 1);
    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);
    drain();

    run_batch(140);
    drain();

    write_reg(RegWidth, 1023);
    write_reg(RegHeight, 1023);
    write_reg(RegStep, 0);
    write_reg(RegScale, 65535);
    write_reg(RegOutline, 0);
    calm = 1'b1;
    run_batch(110);
    calm = 1'b0;
    drain();

    write_reg(RegWidth, 1);
    write_reg(RegHeight, 1);
    write_reg(RegStep, 65535);
    write_reg(RegScale, 0);
    write_reg(RegOutline, 7);
    write_reg(RegBack, 16'hFFFF);
    run_batch(100);
    drain();

    write_reg(RegWidth, 0);
    write_reg(RegHeight, 300);
    write_reg(RegStep, 1);
    write_reg(RegScale, 4096);
    write_reg(RegOutline, $urandom_range(15));
    run_batch(100);
    drain();

    write_reg(RegWidth, $urandom_range(1, 512));
    write_reg(RegHeight, $urandom_range(1, 512));
    write_reg(RegStep, $urandom_range(16, 2000));
    write_reg(RegScale, $urandom_range(65535));
    write_reg(RegOutline, $urandom_range(15));
    write_reg(RegBack, $urandom_range(65535));
    run_batch(200);
    drain();
    repeat (200) @(negedge clk);

    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
